/* hw/rtl/i2cras_pkg.sv */
// Shared types and codes for the I2C register access sequencer.
package i2cras_pkg;

  // Bus engine status codes after masking off the low three bits.
  localparam logic [7:0] ST_START     = 8'h08;
  localparam logic [7:0] ST_REP_START = 8'h10;
  localparam logic [7:0] ST_SLAW_ACK  = 8'h18;
  localparam logic [7:0] ST_SLAW_NACK = 8'h20;
  localparam logic [7:0] ST_DATA_ACK  = 8'h28;
  localparam logic [7:0] ST_DATA_NACK = 8'h30;
  localparam logic [7:0] ST_SLAR_ACK  = 8'h40;
  localparam logic [7:0] ST_SLAR_NACK = 8'h48;
  localparam logic [7:0] ST_RX_ACK    = 8'h50;
  localparam logic [7:0] ST_RX_NACK   = 8'h58;
  localparam logic [7:0] STATUS_MASK  = 8'hF8;

  // Bus commands sent to the engine.
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_SEND  = 3'd2;
  localparam logic [2:0] CMD_RACK  = 3'd3;
  localparam logic [2:0] CMD_RNACK = 3'd4;
  localparam logic [2:0] CMD_STOP  = 3'd5;

  // Item actions.
  localparam logic ACT_BEGIN    = 1'b0;
  localparam logic ACT_COMPLETE = 1'b1;

  // Error flag bit positions.
  localparam int ERR_ATTEMPTS   = 0;
  localparam int ERR_START      = 2;
  localparam int ERR_SLAW_NACK  = 3;
  localparam int ERR_SLAW_OTHER = 5;
  localparam int ERR_PTR_NACK   = 6;
  localparam int ERR_PTR_OTHER  = 8;
  localparam int ERR_RSTART     = 10;
  localparam int ERR_SLAR_NACK  = 11;
  localparam int ERR_WDATA_NACK = 12;
  localparam int ERR_OTHER      = 13;
  localparam int ERR_RDATA      = 15;

  localparam logic [3:0] ATTEMPT_LIMIT_RESET = 4'd5;

  typedef struct packed {
    logic       action;
    logic       is_read;
    logic [7:0] device_address;
    logic [7:0] register_pointer;
    logic [7:0] byte_count;
    logic [7:0] bus_status;
    logic [7:0] read_byte;
    logic [7:0] write_byte;
  } item_t;

  typedef struct packed {
    logic [2:0]  bus_command;
    logic [7:0]  tx_byte;
    logic [7:0]  rx_byte;
    logic        rx_valid;
    logic        done_res;
    logic [15:0] error_flags;
  } result_t;

endpackage

/* hw/rtl/i2cras_chan.sv */
// Valid/ready channel interface carrying one payload per transfer.
interface i2cras_chan #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* hw/rtl/i2c_register_access_sequencer.sv */
// I2C register access sequencer: turns begin and bus completion items into bus commands.
// The sequencer takes at most one item per cycle, giving exactly one result for each item,
// held in an output register in the cycle after the item transfer. The item side is ready
// whenever the output register is empty or its result is being taken in the same cycle,
// so with a ready consumer the sustained rate is one item per cycle; the only limit is the
// single next-state update between the sequencing registers and the output register.
// The attempt limit may be changed through cfg_wr_en/cfg_wr_data while no transaction
// is running; it resets to five START attempts.
module i2c_register_access_sequencer (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       cfg_wr_en,
  input  logic [3:0]                                 cfg_wr_data,
  i2cras_chan.sink                                   item,
  i2cras_chan.source                                 result
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_START  = 3'd1;
  localparam logic [2:0] PH_SLAW   = 3'd2;
  localparam logic [2:0] PH_PTR    = 3'd3;
  localparam logic [2:0] PH_WDATA  = 3'd4;
  localparam logic [2:0] PH_RSTART = 3'd5;
  localparam logic [2:0] PH_SLAR   = 3'd6;
  localparam logic [2:0] PH_RDATA  = 3'd7;

  logic [3:0]  attempt_limit;
  logic [2:0]  phase, phase_next;
  logic        read_mode, read_mode_next;
  logic [7:0]  saved_address, saved_address_next;
  logic [7:0]  saved_pointer, saved_pointer_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [3:0]  attempts_used, attempts_used_next;
  logic [15:0] error_word, error_word_next;

  i2cras_pkg::result_t res_q, res_next;
  logic                res_valid;
  logic                accept;

  i2cras_pkg::item_t in_item;
  logic [7:0]        st;
  logic [7:0]        bytes_dec;

  assign in_item   = item.payload;
  assign st        = in_item.bus_status & i2cras_pkg::STATUS_MASK;
  assign bytes_dec = bytes_left - 8'd1;

  assign item.ready     = !res_valid || result.ready;
  assign accept         = item.valid && item.ready;
  assign result.valid   = res_valid;
  assign result.payload = res_q;

  always_comb begin
    logic do_start;
    logic done;
    logic [2:0] cmd;
    logic [7:0] tx;
    logic [7:0] rx;
    logic rxv;

    do_start = 1'b0;
    done     = 1'b0;
    cmd      = i2cras_pkg::CMD_NONE;
    tx       = 8'd0;
    rx       = 8'd0;
    rxv      = 1'b0;

    phase_next         = phase;
    read_mode_next     = read_mode;
    saved_address_next = saved_address;
    saved_pointer_next = saved_pointer;
    bytes_left_next    = bytes_left;
    attempts_used_next = attempts_used;
    error_word_next    = error_word;

    if (in_item.action == i2cras_pkg::ACT_BEGIN) begin
      // A begin drops whatever transaction was running.
      read_mode_next     = in_item.is_read;
      saved_address_next = in_item.device_address;
      saved_pointer_next = in_item.register_pointer;
      bytes_left_next    = in_item.byte_count;
      attempts_used_next = 4'd0;
      error_word_next    = 16'd0;
      do_start           = 1'b1;
    end else begin
      case (phase)
        PH_START: begin
          if (st == i2cras_pkg::ST_START || st == i2cras_pkg::ST_REP_START) begin
            cmd        = i2cras_pkg::CMD_SEND;
            tx         = saved_address;
            phase_next = PH_SLAW;
          end else begin
            error_word_next[i2cras_pkg::ERR_START] = 1'b1;
            done       = 1'b1;
            phase_next = PH_IDLE;
          end
        end
        PH_SLAW: begin
          if (st == i2cras_pkg::ST_SLAW_ACK) begin
            cmd        = i2cras_pkg::CMD_SEND;
            tx         = saved_pointer;
            phase_next = PH_PTR;
          end else if (st == i2cras_pkg::ST_SLAW_NACK) begin
            error_word_next[i2cras_pkg::ERR_SLAW_NACK] = 1'b1;
            do_start = 1'b1;
          end else begin
            error_word_next[i2cras_pkg::ERR_SLAW_OTHER] = 1'b1;
            cmd        = i2cras_pkg::CMD_STOP;
            done       = 1'b1;
            phase_next = PH_IDLE;
          end
        end
        PH_PTR: begin
          if (st == i2cras_pkg::ST_DATA_ACK) begin
            if (read_mode) begin
              cmd        = i2cras_pkg::CMD_START;
              phase_next = PH_RSTART;
            end else if (bytes_left != 8'd0) begin
              cmd        = i2cras_pkg::CMD_SEND;
              tx         = in_item.write_byte;
              phase_next = PH_WDATA;
            end else begin
              cmd        = i2cras_pkg::CMD_STOP;
              done       = 1'b1;
              phase_next = PH_IDLE;
            end
          end else if (st == i2cras_pkg::ST_DATA_NACK) begin
            error_word_next[i2cras_pkg::ERR_PTR_NACK] = 1'b1;
            do_start = 1'b1;
          end else begin
            error_word_next[i2cras_pkg::ERR_PTR_OTHER] = 1'b1;
            cmd        = i2cras_pkg::CMD_STOP;
            done       = 1'b1;
            phase_next = PH_IDLE;
          end
        end
        PH_WDATA: begin
          if (st == i2cras_pkg::ST_DATA_ACK) begin
            bytes_left_next = bytes_dec;
            if (bytes_dec != 8'd0) begin
              cmd = i2cras_pkg::CMD_SEND;
              tx  = in_item.write_byte;
            end else begin
              cmd        = i2cras_pkg::CMD_STOP;
              done       = 1'b1;
              phase_next = PH_IDLE;
            end
          end else begin
            if (st == i2cras_pkg::ST_DATA_NACK) begin
              error_word_next[i2cras_pkg::ERR_WDATA_NACK] = 1'b1;
            end else begin
              error_word_next[i2cras_pkg::ERR_OTHER] = 1'b1;
            end
            cmd        = i2cras_pkg::CMD_STOP;
            done       = 1'b1;
            phase_next = PH_IDLE;
          end
        end
        PH_RSTART: begin
          if (st == i2cras_pkg::ST_START || st == i2cras_pkg::ST_REP_START) begin
            cmd        = i2cras_pkg::CMD_SEND;
            tx         = saved_address | 8'h01;
            phase_next = PH_SLAR;
          end else begin
            error_word_next[i2cras_pkg::ERR_RSTART] = 1'b1;
            cmd        = i2cras_pkg::CMD_STOP;
            done       = 1'b1;
            phase_next = PH_IDLE;
          end
        end
        PH_SLAR: begin
          if (st == i2cras_pkg::ST_SLAR_ACK && bytes_left != 8'd0) begin
            cmd        = (bytes_left == 8'd1) ? i2cras_pkg::CMD_RNACK : i2cras_pkg::CMD_RACK;
            phase_next = PH_RDATA;
          end else begin
            if (st == i2cras_pkg::ST_SLAR_NACK) begin
              error_word_next[i2cras_pkg::ERR_SLAR_NACK] = 1'b1;
            end else if (st != i2cras_pkg::ST_SLAR_ACK) begin
              error_word_next[i2cras_pkg::ERR_OTHER] = 1'b1;
            end
            cmd        = i2cras_pkg::CMD_STOP;
            done       = 1'b1;
            phase_next = PH_IDLE;
          end
        end
        PH_RDATA: begin
          if (st == i2cras_pkg::ST_RX_NACK) begin
            rx         = in_item.read_byte;
            rxv        = 1'b1;
            cmd        = i2cras_pkg::CMD_STOP;
            done       = 1'b1;
            phase_next = PH_IDLE;
          end else if (st == i2cras_pkg::ST_RX_ACK) begin
            rx              = in_item.read_byte;
            rxv             = 1'b1;
            bytes_left_next = bytes_dec;
            if (bytes_dec != 8'd0) begin
              cmd = (bytes_dec == 8'd1) ? i2cras_pkg::CMD_RNACK : i2cras_pkg::CMD_RACK;
            end else begin
              cmd        = i2cras_pkg::CMD_STOP;
              done       = 1'b1;
              phase_next = PH_IDLE;
            end
          end else begin
            error_word_next[i2cras_pkg::ERR_RDATA] = 1'b1;
            cmd        = i2cras_pkg::CMD_STOP;
            done       = 1'b1;
            phase_next = PH_IDLE;
          end
        end
        default: begin
          // A completion with no transaction running is ignored.
          phase_next = PH_IDLE;
        end
      endcase
    end

    // New START attempt, unless the attempt budget is spent.
    if (do_start) begin
      if (attempts_used_next >= attempt_limit) begin
        error_word_next[i2cras_pkg::ERR_ATTEMPTS] = 1'b1;
        cmd        = i2cras_pkg::CMD_NONE;
        done       = 1'b1;
        phase_next = PH_IDLE;
      end else begin
        attempts_used_next = attempts_used_next + 4'd1;
        cmd        = i2cras_pkg::CMD_START;
        phase_next = PH_START;
      end
    end

    res_next.bus_command = cmd;
    res_next.tx_byte     = tx;
    res_next.rx_byte     = rx;
    res_next.rx_valid    = rxv;
    res_next.done_res    = done;
    res_next.error_flags = done ? error_word_next : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      attempt_limit <= i2cras_pkg::ATTEMPT_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      attempt_limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      read_mode     <= 1'b0;
      saved_address <= 8'd0;
      saved_pointer <= 8'd0;
      bytes_left    <= 8'd0;
      attempts_used <= 4'd0;
      error_word    <= 16'd0;
      res_valid     <= 1'b0;
    end else begin
      if (accept) begin
        phase         <= phase_next;
        read_mode     <= read_mode_next;
        saved_address <= saved_address_next;
        saved_pointer <= saved_pointer_next;
        bytes_left    <= bytes_left_next;
        attempts_used <= attempts_used_next;
        error_word    <= error_word_next;
        res_valid     <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_q <= res_next;
    end
  end

  // A finished transaction leaves the sequencer idle.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_q.done_res |-> phase == PH_IDLE)
    else $error("done reported while a transaction is still running");

  // A received byte only comes with a receive or stop command.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_q.rx_valid |->
      res_q.bus_command == i2cras_pkg::CMD_STOP ||
      res_q.bus_command == i2cras_pkg::CMD_RACK ||
      res_q.bus_command == i2cras_pkg::CMD_RNACK)
    else $error("received byte delivered with an unexpected bus command");

  // Error flags are reported only together with done.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_q.done_res |-> res_q.error_flags == 16'd0)
    else $error("error flags reported without done");

  // A START is issued only after at least one attempt has been counted.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_q.bus_command == i2cras_pkg::CMD_START |-> attempts_used != 4'd0)
    else $error("START issued without counting an attempt");

endmodule
